>>> rtl/cluster_flip_energy_delta_defines.svh
// Assertion helpers for the cluster flip energy delta block.
// Each assertion is clocked on clk and held off while rst_n is low.
`ifndef CLUSTER_FLIP_ENERGY_DELTA_DEFINES_SVH
`define CLUSTER_FLIP_ENERGY_DELTA_DEFINES_SVH

`ifndef SYNTH
`define CFED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFED_ASSERT_IMP(lbl, ante, cons)
`define CFED_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/cfed_pkg.sv
package cfed_pkg;

  typedef enum logic [2:0] {
    OP_EDGE   = 3'd0,
    OP_SPIN   = 3'd1,
    OP_VERT   = 3'd2,
    OP_ACCEPT = 3'd3,
    OP_READ   = 3'd4,
    OP_ENERGY = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    K_DELTA  = 2'd0,
    K_ENERGY = 2'd1,
    K_SPIN   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_V_RD,
    ST_V_CHK,
    ST_E_RD,
    ST_E_NB,
    ST_E_ACC,
    ST_V_ADD,
    ST_V_END,
    ST_W_RD,
    ST_W_M,
    ST_W_FX,
    ST_W_DONE,
    ST_ACC_OUT,
    ST_READ_OUT
  } state_t;

  localparam logic signed [39:0] E_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] E_MIN = {1'b1, {39{1'b0}}};

  // Clamp a 41-bit sum to the signed 40-bit range
  function automatic logic signed [39:0] sat40(input logic signed [40:0] s);
    logic signed [39:0] r;
    if (s[40] != s[39]) begin
      r = s[40] ? E_MIN : E_MAX;
    end else begin
      r = s[39:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cfed_ram.sv
module cfed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cfed_front.sv
module cfed_front #(
  parameter int VERTICES    = 1024,
  parameter int WEIGHT_BITS = 16,
  localparam int VB = $clog2(VERTICES),
  localparam int IW = 3 + VB + 2 + VB + WEIGHT_BITS + 1 + 1 + 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_operation,
  input  logic [9:0]          in_vertex,
  input  logic [1:0]          in_slot,
  input  logic [9:0]          in_neighbour,
  input  logic signed [15:0]  in_weight,
  input  logic                in_spin_value,
  input  logic                in_last,
  input  logic signed [39:0]  in_energy_value,
  input  logic                clr_busy,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [IW-1:0]       push_data
);
  import cfed_pkg::*;

  // Index reduction by reciprocal multiply: exact for 10-bit inputs
  localparam int K     = 11 + VB;
  localparam int RECIP = ((1 << K) + VERTICES - 1) / VERTICES;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = 10 + RW;
  localparam int MW    = 11 + VB;
  localparam longint WMAX = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam longint WMIN = -WMAX - 64'sd1;

  logic                s1_valid_r;
  logic [2:0]          op_r;
  logic [9:0]          v_r;
  logic [1:0]          slot_r;
  logic [9:0]          nb_r;
  logic signed [15:0]  w_r;
  logic                sp_r;
  logic                last_r;
  logic signed [39:0]  e_r;
  logic [9:0]          qv_r;
  logic [9:0]          qn_r;
  logic [PW-1:0]       prod_v;
  logic [PW-1:0]       prod_n;
  logic [VB-1:0]       v_red;
  logic [VB-1:0]       nb_red;
  logic [WEIGHT_BITS-1:0] w_sat;
  longint              w_ext;
  logic                push;

  assign push     = s1_valid_r && push_ready;
  assign in_ready = !clr_busy && (!s1_valid_r || push);

  assign prod_v = PW'(in_vertex) * PW'(RECIP);
  assign prod_n = PW'(in_neighbour) * PW'(RECIP);

  // Hold the accepted item and its quotients for one stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (push) begin
      s1_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      v_r    <= in_vertex;
      slot_r <= in_slot;
      nb_r   <= in_neighbour;
      w_r    <= in_weight;
      sp_r   <= in_spin_value;
      last_r <= in_last;
      e_r    <= in_energy_value;
      qv_r   <= 10'(prod_v >> K);
      qn_r   <= 10'(prod_n >> K);
    end
  end

  // Finish the remainders and clamp the weight
  always_comb begin
    v_red  = VB'(MW'(v_r) - MW'(qv_r) * MW'(VERTICES));
    nb_red = VB'(MW'(nb_r) - MW'(qn_r) * MW'(VERTICES));
    w_ext  = longint'(w_r);
    if (w_ext > WMAX) begin
      w_sat = WEIGHT_BITS'(WMAX);
    end else if (w_ext < WMIN) begin
      w_sat = WEIGHT_BITS'(WMIN);
    end else begin
      w_sat = WEIGHT_BITS'(w_ext);
    end
  end

  assign push_valid = s1_valid_r;
  assign push_data  = {op_r, v_red, slot_r, nb_red, w_sat, sp_r, last_r, e_r};

endmodule

>>> rtl/cfed_queue.sv
module cfed_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import cfed_pkg::*;

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             wr_en;
  logic             rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = slot_q[rptr_r];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= !wptr_r;
      end
      if (rd_en) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) begin
      slot_q[wptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/cfed_back.sv
module cfed_back #(
  parameter int VERTICES    = 1024,
  parameter int DEGREE      = 4,
  parameter int MAX_CLUSTER = 512,
  parameter int WEIGHT_BITS = 16,
  localparam int VB = $clog2(VERTICES),
  localparam int IW = 3 + VB + 2 + VB + WEIGHT_BITS + 1 + 1 + 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [IW-1:0]      q_data,
  output logic               clr_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [39:0] out_value,
  output logic               out_spin_out,
  output logic               out_overflow
);
  import cfed_pkg::*;

  localparam int WB  = WEIGHT_BITS;
  localparam int EAW = $clog2(VERTICES * DEGREE);
  localparam int MAW = $clog2(MAX_CLUSTER);
  localparam int LW  = $clog2(MAX_CLUSTER + 1);
  localparam int SLW = $clog2(DEGREE + 1);

  // Queue item fields
  logic [2:0]          q_op;
  logic [VB-1:0]       q_v;
  logic [1:0]          q_slot;
  logic [VB-1:0]       q_nb;
  logic [WB-1:0]       q_w;
  logic                q_sp;
  logic                q_last;
  logic signed [39:0]  q_e;

  assign {q_op, q_v, q_slot, q_nb, q_w, q_sp, q_last, q_e} = q_data;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [VB-1:0]       v_r;
  logic [1:0]          slot_r;
  logic [VB-1:0]       nb_r;
  logic [WB-1:0]       w_r;
  logic                sp_r;
  logic                last_r;
  logic signed [39:0]  e_r;
  logic [LW-1:0]       len_r, len_nxt;
  logic signed [39:0]  delta_r, delta_nxt;
  logic signed [39:0]  energy_r, energy_nxt;
  logic                ready_r, ready_nxt;
  logic                ovf_r, ovf_nxt;
  logic                acc_ov_r, acc_ov_nxt;
  logic [SLW-1:0]      si_r, si_nxt;
  logic [LW-1:0]       k_r, k_nxt;
  logic [VB-1:0]       m_r, m_nxt;
  logic                sv_r, sv_nxt;
  logic [WB-1:0]       ew_r, ew_nxt;
  logic [VB-1:0]       clr_r, clr_nxt;
  logic [2:0]          deg_cfg_r;
  logic [SLW-1:0]      deg_eff;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic signed [39:0]  out_value_r;
  logic                out_spin_r;
  logic                out_ov_r;
  logic                out_free;
  logic                load_out;
  kind_t               ld_kind;
  logic signed [39:0]  ld_value;
  logic                ld_spin;
  logic                ld_ov;

  // Memory ports
  logic                spin_we, spin_wd, spin_rd;
  logic                mark_we, mark_wd, mark_rd;
  logic [VB-1:0]       sm_waddr, sm_raddr;
  logic                edge_we;
  logic [EAW-1:0]      edge_waddr, edge_raddr;
  logic [VB+WB-1:0]    edge_wd, edge_rd;
  logic                mem_we;
  logic [VB-1:0]       mem_rd;

  logic signed [40:0]  w2;
  logic signed [40:0]  dsum;

  function automatic logic signed [39:0] w_r_ext(input logic [WB-1:0] w);
    return 40'(signed'(w));
  endfunction

  cfed_ram #(.WIDTH(1), .DEPTH(VERTICES)) u_spin_ram (
    .clk(clk), .we(spin_we), .waddr(sm_waddr), .wdata(spin_wd),
    .raddr(sm_raddr), .rdata(spin_rd)
  );

  cfed_ram #(.WIDTH(1), .DEPTH(VERTICES)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(sm_waddr), .wdata(mark_wd),
    .raddr(sm_raddr), .rdata(mark_rd)
  );

  cfed_ram #(.WIDTH(VB + WB), .DEPTH(VERTICES * DEGREE)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wd),
    .raddr(edge_raddr), .rdata(edge_rd)
  );

  cfed_ram #(.WIDTH(VB), .DEPTH(MAX_CLUSTER)) u_member_ram (
    .clk(clk), .we(mem_we), .waddr(len_r[MAW-1:0]), .wdata(v_r),
    .raddr(k_r[MAW-1:0]), .rdata(mem_rd)
  );

  // Clamp the degree register to 1..DEGREE
  always_comb begin
    if (deg_cfg_r == 3'd0) begin
      deg_eff = SLW'(1);
    end else if (32'(deg_cfg_r) > DEGREE) begin
      deg_eff = SLW'(DEGREE);
    end else begin
      deg_eff = SLW'(deg_cfg_r);
    end
  end

  assign q_ready  = (state_r == ST_IDLE);
  assign clr_busy = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_ready;

  // Edge term: add 2w when spin agreement matches the mark, else subtract
  assign w2   = 41'(signed'(w_r_ext(ew_r))) <<< 1;
  assign dsum = ((sv_r == spin_rd) == mark_rd) ? (41'(delta_r) + w2) : (41'(delta_r) - w2);

  // Sequencer: next state, memory control and datapath updates
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    delta_nxt  = delta_r;
    energy_nxt = energy_r;
    ready_nxt  = ready_r;
    ovf_nxt    = ovf_r;
    acc_ov_nxt = acc_ov_r;
    si_nxt     = si_r;
    k_nxt      = k_r;
    m_nxt      = m_r;
    sv_nxt     = sv_r;
    ew_nxt     = ew_r;
    clr_nxt    = clr_r;
    spin_we    = 1'b0;
    spin_wd    = 1'b0;
    mark_we    = 1'b0;
    mark_wd    = 1'b0;
    sm_waddr   = v_r;
    sm_raddr   = v_r;
    edge_we    = 1'b0;
    edge_waddr = EAW'(v_r) * EAW'(DEGREE) + EAW'(slot_r);
    edge_raddr = EAW'(v_r) * EAW'(DEGREE) + EAW'(si_r);
    edge_wd    = {nb_r, w_r};
    mem_we     = 1'b0;
    load_out   = 1'b0;
    ld_kind    = K_DELTA;
    ld_value   = delta_r;
    ld_spin    = 1'b0;
    ld_ov      = ovf_r;

    unique case (state_r)
      ST_CLEAR: begin
        spin_we  = 1'b1;
        mark_we  = 1'b1;
        sm_waddr = clr_r;
        clr_nxt  = clr_r + VB'(1);
        if (32'(clr_r) == VERTICES - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        case (op_r) inside
          OP_EDGE: begin
            edge_we = (32'(slot_r) < DEGREE);
          end
          OP_SPIN: begin
            spin_we = 1'b1;
            spin_wd = sp_r;
          end
          OP_ENERGY: begin
            energy_nxt = e_r;
          end
          OP_READ: begin
            state_nxt = ST_READ_OUT;
          end
          OP_VERT, OP_ACCEPT: begin
            k_nxt = '0;
            if (ready_r) begin
              state_nxt = (len_r == '0) ? ST_W_DONE : ST_W_RD;
            end else if (op_r == OP_VERT) begin
              state_nxt = ST_V_RD;
            end else begin
              acc_ov_nxt = 1'b0;
              state_nxt  = ST_ACC_OUT;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_V_RD: begin
        state_nxt = ST_V_CHK;
      end
      ST_V_CHK: begin
        sv_nxt = spin_rd;
        si_nxt = '0;
        if (mark_rd) begin
          state_nxt = ST_V_END;
        end else if (len_r == LW'(MAX_CLUSTER)) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_V_END;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_NB;
      end
      ST_E_NB: begin
        sm_raddr  = edge_rd[VB+WB-1:WB];
        ew_nxt    = edge_rd[WB-1:0];
        state_nxt = ST_E_ACC;
      end
      ST_E_ACC: begin
        delta_nxt = sat40(dsum);
        si_nxt    = si_r + SLW'(1);
        state_nxt = (si_r + SLW'(1) == deg_eff) ? ST_V_ADD : ST_E_RD;
      end
      ST_V_ADD: begin
        mem_we    = 1'b1;
        mark_we   = 1'b1;
        mark_wd   = 1'b1;
        len_nxt   = len_r + LW'(1);
        state_nxt = ST_V_END;
      end
      ST_V_END: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out  = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_W_RD: begin
        state_nxt = ST_W_M;
      end
      ST_W_M: begin
        sm_raddr  = mem_rd;
        m_nxt     = mem_rd;
        state_nxt = ST_W_FX;
      end
      ST_W_FX: begin
        sm_waddr  = m_r;
        mark_we   = 1'b1;
        spin_we   = (op_r == OP_ACCEPT);
        spin_wd   = !spin_rd;
        k_nxt     = k_r + LW'(1);
        state_nxt = (k_r + LW'(1) == len_r) ? ST_W_DONE : ST_W_RD;
      end
      ST_W_DONE: begin
        if (op_r == OP_ACCEPT) begin
          energy_nxt = sat40(41'(energy_r) + 41'(delta_r));
          acc_ov_nxt = ovf_r;
          state_nxt  = ST_ACC_OUT;
        end else begin
          state_nxt = ST_V_RD;
        end
        len_nxt   = '0;
        delta_nxt = '0;
        ovf_nxt   = 1'b0;
        ready_nxt = 1'b0;
      end
      ST_ACC_OUT: begin
        ld_kind  = K_ENERGY;
        ld_value = energy_r;
        ld_ov    = acc_ov_r;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ_OUT: begin
        ld_kind  = K_SPIN;
        ld_value = '0;
        ld_spin  = spin_rd;
        ld_ov    = 1'b0;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      len_r     <= '0;
      delta_r   <= '0;
      energy_r  <= '0;
      ready_r   <= 1'b0;
      ovf_r     <= 1'b0;
      acc_ov_r  <= 1'b0;
      deg_cfg_r <= 3'd4;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      len_r    <= len_nxt;
      delta_r  <= delta_nxt;
      energy_r <= energy_nxt;
      ready_r  <= ready_nxt;
      ovf_r    <= ovf_nxt;
      acc_ov_r <= acc_ov_nxt;
      if (cfg_wr_en) begin
        deg_cfg_r <= cfg_wr_data;
      end
    end
  end

  // Working registers and the popped item
  always_ff @(posedge clk) begin
    si_r <= si_nxt;
    k_r  <= k_nxt;
    m_r  <= m_nxt;
    sv_r <= sv_nxt;
    ew_r <= ew_nxt;
    if (q_valid && q_ready) begin
      op_r   <= op_t'(q_op);
      v_r    <= q_v;
      slot_r <= q_slot;
      nb_r   <= q_nb;
      w_r    <= q_w;
      sp_r   <= q_sp;
      last_r <= q_last;
      e_r    <= q_e;
    end
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_kind_r  <= ld_kind;
      out_value_r <= ld_value;
      out_spin_r  <= ld_spin;
      out_ov_r    <= ld_ov;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_value_r;
  assign out_spin_out = out_spin_r;
  assign out_overflow = out_ov_r;

endmodule

>>> rtl/cluster_flip_energy_delta.sv
// Cluster flip energy delta unit.
// Input channel (in_valid/in_ready) takes one operation per transfer: edge
// write, spin write, cluster vertex, accept, spin read or energy set.
// Result channel (out_valid/out_ready) returns at most one result per item:
// the cluster delta on a vertex marked last, the running energy on accept,
// or the spin on a read. cfg_wr_en/cfg_wr_data set the edge slots in use.
// A front stage reduces indices and clamps weights, a two-entry queue
// decouples it from the back sequencer, which owns the spin, mark, edge and
// member memories (one read and one write port each, registered read).
// In the back sequencer a cluster vertex reads each edge slot in use in turn
// (a duplicate or overflow vertex reads none), and accept flips the spin of
// each member of a finished cluster; a new vertex after a finished cluster
// first clears the mark of each member. Items pass through the front stage.
// After reset the spin and mark memories are cleared, one entry a cycle,
// over all VERTICES entries; in_ready stays low meanwhile.
// A stalled receiver holds the result; the queue keeps accepting until full.
`include "cluster_flip_energy_delta_defines.svh"

module cluster_flip_energy_delta #(
  parameter int VERTICES    = 1024,
  parameter int DEGREE      = 4,
  parameter int MAX_CLUSTER = 512,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [9:0]         in_vertex,
  input  logic [1:0]         in_slot,
  input  logic [9:0]         in_neighbour,
  input  logic signed [15:0] in_weight,
  input  logic               in_spin_value,
  input  logic               in_last,
  input  logic signed [39:0] in_energy_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [39:0] out_value,
  output logic               out_spin_out,
  output logic               out_overflow
);
  import cfed_pkg::*;

  localparam int VB = $clog2(VERTICES);
  localparam int IW = 3 + VB + 2 + VB + WEIGHT_BITS + 1 + 1 + 40;

  logic          clr_busy;
  logic          push_valid, push_ready;
  logic [IW-1:0] push_data;
  logic          q_valid, q_ready;
  logic [IW-1:0] q_data;

  cfed_front #(.VERTICES(VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_vertex(in_vertex), .in_slot(in_slot),
    .in_neighbour(in_neighbour), .in_weight(in_weight),
    .in_spin_value(in_spin_value), .in_last(in_last),
    .in_energy_value(in_energy_value), .clr_busy(clr_busy),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  cfed_queue #(.WIDTH(IW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  cfed_back #(
    .VERTICES(VERTICES), .DEGREE(DEGREE),
    .MAX_CLUSTER(MAX_CLUSTER), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .clr_busy(clr_busy),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_value(out_value), .out_spin_out(out_spin_out),
    .out_overflow(out_overflow)
  );

  // No transfer in while the memories are being cleared
  `CFED_ASSERT_IMP(a_no_in_during_clear, clr_busy, !in_ready)
  // A spin read carries no energy and no overflow
  `CFED_ASSERT_IMP(a_spin_read_clean, out_valid && out_kind == K_SPIN,
    out_value == '0 && !out_overflow)
  // Energy results carry no spin bit
  `CFED_ASSERT_IMP(a_energy_no_spin, out_valid && out_kind != K_SPIN, !out_spin_out)
  // Once clearing has ended it does not start again before reset
  `CFED_ASSERT_NXT(a_clear_once, !clr_busy, !clr_busy)

endmodule

>>> sim/cfed_checker.sv
module cfed_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [9:0]         in_vertex,
  input  logic [1:0]         in_slot,
  input  logic [9:0]         in_neighbour,
  input  logic signed [15:0] in_weight,
  input  logic               in_spin_value,
  input  logic               in_last,
  input  logic signed [39:0] in_energy_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_kind,
  input  logic signed [39:0] out_value,
  input  logic               out_spin_out,
  input  logic               out_overflow,
  output int                 fail_count,
  output int                 pending_count
);
  import cfed_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [39:0] value;
    logic               spin;
    logic               ovf;
  } result_t;

  localparam logic signed [40:0] SUM_MAX = 41'sd549755813887;
  localparam logic signed [40:0] SUM_MIN = -41'sd549755813888;

  result_t            expected_q[$];
  logic               spin_mem[1024];
  logic [9:0]         nbr_mem[4096];
  logic signed [15:0] wgt_mem[4096];
  logic               marked[1024];
  logic [9:0]         members[$];
  logic signed [39:0] delta_acc;
  logic signed [39:0] energy_acc;
  logic               finished;
  logic               ovf_flag;
  logic [2:0]         degree_reg;

  assign pending_count = expected_q.size();

  function automatic logic signed [39:0] clamp_add(logic signed [39:0] a,
                                                   logic signed [39:0] b);
    logic signed [40:0] s;
    s = 41'(a) + 41'(b);
    if (s > SUM_MAX) return SUM_MAX[39:0];
    if (s < SUM_MIN) return SUM_MIN[39:0];
    return s[39:0];
  endfunction

  function automatic void drop_cluster();
    foreach (marked[i]) marked[i] = 1'b0;
    members.delete();
    delta_acc = '0;
    ovf_flag  = 1'b0;
    finished  = 1'b0;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Advance the predicted state by one accepted operation
  task automatic predict_op();
    int                 deg;
    int                 base;
    logic [9:0]         n;
    logic signed [39:0] term;
    result_t            r;
    case (in_operation)
      OP_EDGE: begin
        nbr_mem[{in_vertex, in_slot}] = in_neighbour;
        wgt_mem[{in_vertex, in_slot}] = in_weight;
      end
      OP_SPIN: spin_mem[in_vertex] = in_spin_value;
      OP_VERT: begin
        deg = degree_reg;
        if (finished) drop_cluster();
        if (deg < 1) deg = 1;
        if (deg > 4) deg = 4;
        if (marked[in_vertex]) begin
        end else if (members.size() >= 512) begin
          ovf_flag = 1'b1;
        end else begin
          base = in_vertex * 4;
          for (int i = 0; i < deg; i++) begin
            n = nbr_mem[base + i];
            term = 40'(wgt_mem[base + i]) * 2;
            if (spin_mem[in_vertex] == spin_mem[n]) term = -term;
            delta_acc = marked[n] ? clamp_add(delta_acc, -term)
                                  : clamp_add(delta_acc, term);
          end
          members.push_back(in_vertex);
          marked[in_vertex] = 1'b1;
        end
        if (in_last) begin
          finished = 1'b1;
          r = '{K_DELTA, delta_acc, 1'b0, ovf_flag};
          expected_q.push_back(r);
        end
      end
      OP_ACCEPT: begin
        r = '{K_ENERGY, '0, 1'b0, 1'b0};
        if (finished) begin
          foreach (members[k]) spin_mem[members[k]] ^= 1'b1;
          energy_acc = clamp_add(energy_acc, delta_acc);
          r.ovf = ovf_flag;
          drop_cluster();
        end
        r.value = energy_acc;
        expected_q.push_back(r);
      end
      OP_READ: begin
        r = '{K_SPIN, '0, spin_mem[in_vertex], 1'b0};
        expected_q.push_back(r);
      end
      OP_ENERGY: energy_acc = in_energy_value;
      default: ;
    endcase
  endtask

  // Track config, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      foreach (spin_mem[i]) spin_mem[i] = 1'b0;
      drop_cluster();
      energy_acc = '0;
      degree_reg = 3'd4;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) degree_reg = cfg_wr_data;
      if (in_valid && in_ready) predict_op();
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result kind", out_kind, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_kind != w.kind) report("kind", out_kind, w.kind);
          if (out_value != w.value) report("value", out_value, w.value);
          if (out_spin_out != w.spin) report("spin_out", out_spin_out, w.spin);
          if (out_overflow != w.ovf) report("overflow", out_overflow, w.ovf);
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import cfed_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [2:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic [9:0]         in_vertex;
  logic [1:0]         in_slot;
  logic [9:0]         in_neighbour;
  logic signed [15:0] in_weight;
  logic               in_spin_value;
  logic               in_last;
  logic signed [39:0] in_energy_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic signed [39:0] out_value;
  logic               out_spin_out;
  logic               out_overflow;
  int                 fail_count;
  int                 pending_count;
  bit                 long_hold;
  bit                 edges_ready;

  cluster_flip_energy_delta DUT (.*);
  cfed_checker u_checker (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Send one operation, then wait a random gap
  task automatic send(op_t op, logic [9:0] v, logic [1:0] sl, logic [9:0] nb,
                      logic signed [15:0] w, logic sv, logic lst,
                      logic signed [39:0] e);
    int gap;
    gap = $urandom_range(0, 5);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_vertex       <= v;
    in_slot         <= sl;
    in_neighbour    <= nb;
    in_weight       <= w;
    in_spin_value   <= sv;
    in_last         <= lst;
    in_energy_value <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_raw(logic [2:0] op, logic [9:0] v, logic lst);
    send(op_t'(op), v, 2'($urandom), 10'($urandom), 16'($urandom), 1'($urandom),
         lst, {8'($urandom), 32'($urandom)});
  endtask

  // Drain all results, wait out the back end, then write the degree
  task automatic set_degree(logic [2:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (1700) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: wait a random number of cycles per result, hold off on request
  always begin
    int wait_n;
    wait_n = $urandom_range(0, 5);
    out_ready <= 1'b0;
    repeat (wait_n) @(posedge clk);
    do begin
      out_ready <= !long_hold;
      @(posedge clk);
    end while (!(out_valid && out_ready));
  end

  initial begin
    #3000000;
    $display("cluster_flip_energy_delta: mismatch");
    $finish;
  end

  initial begin
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0;
    in_operation = '0; in_vertex = '0; in_slot = '0; in_neighbour = '0;
    in_weight = '0; in_spin_value = 1'b0; in_last = 1'b0; in_energy_value = '0;
    long_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every edge slot of the vertices that join clusters
    for (int v = 0; v < 64; v++)
      for (int s = 0; s < 4; s++)
        send(OP_EDGE, 10'(v), 2'(s), 10'($urandom), 16'($urandom), 0, 0, 0);
    for (int s = 0; s < 4; s++)
      send(OP_EDGE, 10'd1023, 2'(s), 10'($urandom), 16'($urandom), 0, 0, 0);

    // Directed: weight and energy extremes, every operation
    send(OP_EDGE, 10'd1023, 2'd3, 10'd1023, 16'sh7FFF, 0, 0, 0);
    send(OP_EDGE, 10'd0, 2'd0, 10'd0, 16'sh8000, 0, 0, 0);
    send(OP_EDGE, 10'd0, 2'd1, 10'd1, 16'sh7FFF, 0, 0, 0);
    send(OP_SPIN, 10'd1023, 0, 0, 0, 1'b1, 0, 0);
    send(OP_READ, 10'd1023, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 10'd0, 0, 0, 0, 0, 0, 0);
    send(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0);
    send(OP_ENERGY, 0, 0, 0, 0, 0, 0, 40'sh7FFFFFFFFF);
    send(OP_VERT, 10'd0, 0, 0, 0, 0, 0, 0);
    send(OP_VERT, 10'd0, 0, 0, 0, 0, 0, 0);
    send(OP_VERT, 10'd1, 0, 0, 0, 0, 1, 0);
    send(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0);
    send(OP_ENERGY, 0, 0, 0, 0, 0, 0, 40'sh8000000000);
    send(OP_VERT, 10'd1023, 0, 0, 0, 0, 1, 0);
    send(OP_VERT, 10'd1023, 0, 0, 0, 0, 1, 0);
    send(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0);
    send_raw(3'd6, 10'd5, 1'b1);
    send_raw(3'd7, 10'd5, 1'b0);
    send(OP_READ, 10'd0, 0, 0, 0, 0, 0, 0);

    // Random phases over several degree settings, extremes and out of range
    for (int ph = 0; ph < 6; ph++) begin
      set_degree(ph == 0 ? 3'd0 : ph == 1 ? 3'd4 : ph == 2 ? 3'd7 : 3'($urandom));
      for (int n = 0; n < 30; n++) begin
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        if (ph == 3 && n == 5) fork
          begin long_hold = 1'b1; repeat (300) @(posedge clk); long_hold = 1'b0; end
        join_none
        if (sel < 5) begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++)
            send(OP_VERT, 10'($urandom_range(0, 63)), 0, 0, 0, 0, j == len - 1, 0);
          send(($urandom_range(0, 2) != 0) ? OP_ACCEPT : OP_READ,
               10'($urandom), 0, 0, 0, 0, 0, 0);
        end else if (sel == 5) begin
          send(OP_EDGE, 10'($urandom), 2'($urandom), 10'($urandom),
               16'($urandom), 0, 0, 0);
        end else if (sel == 6) begin
          send(OP_SPIN, 10'($urandom), 0, 0, 0, 1'($urandom), 0, 0);
        end else if (sel == 7) begin
          send(OP_ENERGY, 0, 0, 0, 0, 0, 0, {8'($urandom), 32'($urandom)});
        end else begin
          send_raw(3'($urandom), 10'($urandom_range(0, 63)), 1'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("cluster_flip_energy_delta: match");
    else
      $display("cluster_flip_energy_delta: mismatch");
    $finish;
  end

endmodule
